>>> sv/lfpr_pkg.sv
// Package: shared types and constants for the local FIFO page replacement block.
package lfpr_pkg;
  localparam int AddrW = 64;
  localparam int PidW = 2;
  localparam int FrameW = 4;
  localparam int CntW = 32;
  localparam int ShiftW = 6;
  localparam int FpW = 5;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 6;
  localparam logic [CfgIdxW-1:0] RegPageShift = 1'd0;
  localparam logic [CfgIdxW-1:0] RegFramesPerProcess = 1'd1;

  typedef struct packed {
    logic [PidW-1:0] process_id;
    logic [AddrW-1:0] page;
  } lfpr_req_t;

  typedef struct packed {
    logic hit;
    logic [FrameW-1:0] frame;
    logic evicted;
    logic [AddrW-1:0] evicted_page;
    logic [CntW-1:0] process_faults;
    logic [CntW-1:0] total_faults;
  } lfpr_res_t;
endpackage

>>> sv/lfpr_if.sv
// Interfaces: request and result channels with valid/ready handshake.
interface lfpr_in_if;
  logic valid;
  logic ready;
  logic [1:0] process_id;
  logic [63:0] address;
  modport source(output valid, process_id, address, input ready);
  modport sink(input valid, process_id, address, output ready);
endinterface

interface lfpr_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic [3:0] frame;
  logic evicted;
  logic [63:0] evicted_page;
  logic [31:0] process_faults;
  logic [31:0] total_faults;
  modport source(output valid, hit, frame, evicted, evicted_page, process_faults,
                 total_faults, input ready);
  modport sink(input valid, hit, frame, evicted, evicted_page, process_faults,
               total_faults, output ready);
endinterface

>>> sv/local_fifo_page_replacement.sv
// Top level: local-allocation FIFO page replacement with per-process frames.
// channel | dir | payload
// in_ch   | in  | process_id[2], address[64]
// out_ch  | out | hit, frame[4], evicted, evicted_page[64], process_faults[32], total_faults[32]
// cfg     | in  | cfg_we, cfg_index[1], cfg_data[6]
// One item per cycle sustained while out_ch is ready; the result passes through the queue, then the lookup register.
// Lookup is a parallel tag compare over the process's active frames.
// Reset clears valid bits, victim pointers and counters.
// A two-entry queue lets front and back stall independently.
module local_fifo_page_replacement #(
  parameter int PROCESSES = 4,
  parameter int MAX_FRAMES = 16
) (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [lfpr_pkg::CfgIdxW-1:0] cfg_index,
  input logic [lfpr_pkg::CfgDataW-1:0] cfg_data,
  lfpr_in_if.sink in_ch,
  lfpr_out_if.source out_ch
);
  import lfpr_pkg::*;
  logic [ShiftW-1:0] page_shift;
  logic [FpW-1:0] frames_per_process;
  logic q_valid, q_ready;
  lfpr_req_t q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift <= ShiftW'(12);
      frames_per_process <= FpW'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegPageShift: page_shift <= cfg_data;
        RegFramesPerProcess: frames_per_process <= cfg_data[FpW-1:0];
        default: ;
      endcase
    end
  end

  lfpr_front #(.PROCESSES(PROCESSES)) u_front (
    .clk, .rst, .page_shift, .in_ch, .q_valid, .q_ready, .q_data
  );

  lfpr_back #(.PROCESSES(PROCESSES), .MAX_FRAMES(MAX_FRAMES)) u_back (
    .clk, .rst, .frames_per_process, .q_valid, .q_ready, .q_data, .out_ch
  );
endmodule

>>> sv/lfpr_front.sv
// Front end: accept items, compute page numbers, hold them in a short queue.
module lfpr_front #(
  parameter int PROCESSES = 4
) (
  input logic clk,
  input logic rst,
  input logic [lfpr_pkg::ShiftW-1:0] page_shift,
  lfpr_in_if.sink in_ch,
  output logic q_valid,
  input logic q_ready,
  output lfpr_pkg::lfpr_req_t q_data
);
  import lfpr_pkg::*;
  localparam int Depth = 2;
  localparam int PmW = PidW + 1;
  lfpr_req_t buf_q [Depth];
  logic wr_ptr, rd_ptr;
  logic [1:0] count;
  logic push, pop;
  lfpr_req_t req;
  logic [PmW-1:0] pid_m;

  always_comb begin
    pid_m = {1'b0, in_ch.process_id};
    for (int k = 0; k < 3; k++) begin
      if (32'(pid_m) >= PROCESSES) pid_m = pid_m - PmW'(PROCESSES);
    end
    req.process_id = pid_m[PidW-1:0];
    req.page = in_ch.address >> page_shift;
  end

  assign in_ch.ready = (count != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (count != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_data = buf_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) buf_q[wr_ptr] <= req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> !pop) else $error("queue underflow");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("count out of range");
`endif
endmodule

>>> sv/lfpr_back.sv
// Back end: per-process tag lookup, FIFO replacement, fault counters, output register.
module lfpr_back #(
  parameter int PROCESSES = 4,
  parameter int MAX_FRAMES = 16
) (
  input logic clk,
  input logic rst,
  input logic [lfpr_pkg::FpW-1:0] frames_per_process,
  input logic q_valid,
  output logic q_ready,
  input lfpr_pkg::lfpr_req_t q_data,
  lfpr_out_if.source out_ch
);
  import lfpr_pkg::*;
  localparam int FIdxW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int PIdxW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int NW = FIdxW + 1;

  logic [AddrW-1:0] page_tag [PROCESSES][MAX_FRAMES];
  logic [MAX_FRAMES-1:0] frame_valid [PROCESSES];
  logic [FIdxW-1:0] victim_pointer [PROCESSES];
  logic [CntW-1:0] fault_count [PROCESSES];
  logic [CntW-1:0] total_fault_count;
  lfpr_res_t res;
  logic res_valid;

  logic [PIdxW-1:0] pid;
  logic [NW-1:0] n;
  logic found, free_found, take;
  logic [FIdxW-1:0] hit_slot, free_slot, v, slot;
  logic [CntW-1:0] pf_next, tf_next;

  assign pid = PIdxW'(q_data.process_id);
  assign take = q_valid && q_ready;
  assign q_ready = !res_valid || out_ch.ready;

  always_comb begin
    if (frames_per_process == '0) n = NW'(1);
    else if (32'(frames_per_process) > MAX_FRAMES) n = NW'(MAX_FRAMES);
    else n = NW'(frames_per_process);
    found = 1'b0;
    free_found = 1'b0;
    hit_slot = '0;
    free_slot = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (NW'(i) < n) begin
        if (frame_valid[pid][i] && page_tag[pid][i] == q_data.page) begin
          found = 1'b1;
          hit_slot = FIdxW'(i);
        end
        if (!frame_valid[pid][i]) begin
          free_found = 1'b1;
          free_slot = FIdxW'(i);
        end
      end
    end
    v = (NW'(victim_pointer[pid]) >= n) ? '0 : victim_pointer[pid];
    slot = found ? hit_slot : (free_found ? free_slot : v);
    pf_next = (fault_count[pid] == '1) ? fault_count[pid] : fault_count[pid] + 1'b1;
    tf_next = (total_fault_count == '1) ? total_fault_count
                                        : total_fault_count + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (take && !found) page_tag[pid][slot] <= q_data.page;
    if (take) begin
      res.hit <= found;
      res.frame <= FrameW'(slot);
      res.evicted <= !found && !free_found;
      res.evicted_page <= (!found && !free_found) ? page_tag[pid][v] : '0;
      res.process_faults <= found ? fault_count[pid] : pf_next;
      res.total_faults <= found ? total_fault_count : tf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      total_fault_count <= '0;
      for (int p = 0; p < PROCESSES; p++) begin
        frame_valid[p] <= '0;
        victim_pointer[p] <= '0;
        fault_count[p] <= '0;
      end
    end else begin
      if (take) res_valid <= 1'b1;
      else if (out_ch.ready) res_valid <= 1'b0;
      if (take && !found) begin
        frame_valid[pid][slot] <= 1'b1;
        fault_count[pid] <= pf_next;
        total_fault_count <= tf_next;
        if (!free_found)
          victim_pointer[pid] <= (NW'(v) + NW'(1) >= n) ? '0 : v + 1'b1;
      end
    end
  end

  assign out_ch.valid = res_valid;
  assign out_ch.hit = res.hit;
  assign out_ch.frame = res.frame;
  assign out_ch.evicted = res.evicted;
  assign out_ch.evicted_page = res.evicted_page;
  assign out_ch.process_faults = res.process_faults;
  assign out_ch.total_faults = res.total_faults;

`ifndef SYNTHESIS
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.hit |-> !res.evicted) else $error("hit with eviction");
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    take && !found && !free_found |-> frame_valid[pid][v]) else $error("evict of free frame");
  a_total_ge: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.total_faults >= res.process_faults) else $error("counter mismatch");
`endif
endmodule
